@@ hw/rtl/csvs_pkg.sv @@
package csvs_pkg;

    localparam int PENDING_DEPTH = 8;
    localparam int PCNT_W        = $clog2(PENDING_DEPTH + 1);
    localparam int PIDX_W        = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

    localparam int CFG_INDEX_W = 8;
    localparam int BYTE_W      = 8;
    localparam int COUNT_W     = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_DELIMITER_0 = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_DELIMITER_1 = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_DELIMITER_2 = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_DELIMITER_3 = CFG_INDEX_W'(3);

    localparam logic [BYTE_W-1:0] DELIM_0_RESET = 8'h2C;
    localparam logic [BYTE_W-1:0] QUOTE_CH      = 8'h22;
    localparam logic [BYTE_W-1:0] LF_CH         = 8'h0A;
    localparam logic [BYTE_W-1:0] CR_CH         = 8'h0D;
    localparam logic [BYTE_W-1:0] SPACE_CH      = 8'h20;
    localparam logic [BYTE_W-1:0] TAB_CH        = 8'h09;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        KIND_BYTE      = 2'd0,
        KIND_FIELD_END = 2'd1,
        KIND_LINE_END  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        SEL_NONE,
        SEL_PEND,
        SEL_BYTE,
        SEL_FEND,
        SEL_LEND
    } emit_sel_t;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } state_t;

    typedef struct packed {
        logic      accept;
        emit_sel_t sel;
        logic      last;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic flush_left;
        logic flush_final;
        logic plan_byte;
        logic plan_fend;
        logic plan_lend;
    } status_t;

endpackage

@@ hw/rtl/csvs_text_if.sv @@
interface csvs_text_if;
    import csvs_pkg::*;

    logic              valid;
    logic              ready;
    logic              action;
    logic [BYTE_W-1:0] char_byte;

    modport source (output valid, output action, output char_byte, input ready);
    modport sink   (input valid, input action, input char_byte, output ready);

endinterface

@@ hw/rtl/csvs_result_if.sv @@
interface csvs_result_if;
    import csvs_pkg::*;

    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [BYTE_W-1:0]  field_byte;
    logic [COUNT_W-1:0] column_count;
    logic               trim_overflow;
    logic               last;

    modport source (
        output valid, output kind, output field_byte, output column_count,
        output trim_overflow, output last, input ready
    );
    modport sink (
        input valid, input kind, input field_byte, input column_count,
        input trim_overflow, input last, output ready
    );

endinterface

@@ hw/rtl/csvs_setup_if.sv @@
interface csvs_setup_if;
    import csvs_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [BYTE_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);

endinterface

@@ hw/rtl/csv_line_field_splitter_core.sv @@
// channel   role    payload
// text      sink    action, char_byte
// result    source  kind, field_byte, column_count, trim_overflow, last
// setup     sink    index, data (delimiter registers 0 to 3)
//
// an item is taken only in idle, then its n results leave one per cycle from
// the output register when result is not stalled; no new item is taken until the last is loaded
// n is at most PENDING_DEPTH + 1, set by the depth of the trailing whitespace
// buffer, which is read one entry per result
// rst_n clears line state and sets delimiter 0 to comma, the rest to unused
// a stall on result holds the current word and pauses the rest of the burst
module csv_line_field_splitter_core (
    input  logic          clk,
    input  logic          rst_n,
    csvs_text_if.sink     text,
    csvs_result_if.source result,
    csvs_setup_if.sink    setup
);
    import csvs_pkg::*;

    cmd_t    cmd;
    status_t sts;
    logic    text_ready;

    assign text.ready = text_ready;

    csvs_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_valid (text.valid),
        .text_ready (text_ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    csvs_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text),
        .result (result),
        .setup  (setup),
        .cmd    (cmd),
        .sts    (sts)
    );

endmodule

@@ hw/rtl/csvs_ctrl.sv @@
module csvs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              text_valid,
    output logic              text_ready,
    input  csvs_pkg::status_t sts,
    output csvs_pkg::cmd_t    cmd
);
    import csvs_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   more_after_pend;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign more_after_pend = sts.plan_byte || sts.plan_fend || sts.plan_lend;

    always_comb
    begin
        state_next = state_reg;
        text_ready = 1'b0;
        cmd.accept = 1'b0;
        cmd.sel    = SEL_NONE;
        cmd.last   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                text_ready = 1'b1;
                if (text_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                priority if (!sts.flush_left && !more_after_pend)
                begin
                    state_next = S_IDLE;
                end
                else if (!sts.out_free)
                begin
                    state_next = S_RUN;
                end
                else if (sts.flush_left)
                begin
                    cmd.sel  = SEL_PEND;
                    cmd.last = sts.flush_final && !more_after_pend;
                end
                else if (sts.plan_byte)
                begin
                    cmd.sel  = SEL_BYTE;
                    cmd.last = !sts.plan_fend && !sts.plan_lend;
                end
                else if (sts.plan_fend)
                begin
                    cmd.sel  = SEL_FEND;
                    cmd.last = !sts.plan_lend;
                end
                else
                begin
                    cmd.sel  = SEL_LEND;
                    cmd.last = 1'b1;
                end
                if (cmd.last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/csvs_dp.sv @@
module csvs_dp (
    input  logic              clk,
    input  logic              rst_n,
    csvs_text_if.sink         text,
    csvs_result_if.source     result,
    csvs_setup_if.sink        setup,
    input  csvs_pkg::cmd_t    cmd,
    output csvs_pkg::status_t sts
);
    import csvs_pkg::*;

    logic [BYTE_W-1:0]  delim_reg [0:3];
    logic [BYTE_W-1:0]  pending_space_reg [0:PENDING_DEPTH-1];

    logic               inside_quotes_reg, inside_quotes_next;
    logic               quote_seen_reg, quote_seen_next;
    logic               field_quoted_reg, field_quoted_next;
    logic               line_blank_reg, line_blank_next;
    logic               field_nonempty_reg, field_nonempty_next;
    logic               line_finished_reg, line_finished_next;
    logic [PCNT_W-1:0]  pending_count_reg, pending_count_next;
    logic [COUNT_W-1:0] fields_reg, fields_next;
    logic               overflow_reg, overflow_next;

    logic               plan_byte_reg, plan_byte_next;
    logic               plan_fend_reg, plan_fend_next;
    logic               plan_lend_reg, plan_lend_next;
    logic [PCNT_W-1:0]  flush_n_reg, flush_n_next;
    logic [PCNT_W-1:0]  flush_idx_reg, flush_idx_next;
    logic [BYTE_W-1:0]  char_reg, char_next;
    logic [COUNT_W-1:0] col_reg, col_next;
    logic               ovf_hold_reg, ovf_hold_next;

    logic               out_valid_reg, out_valid_next;
    kind_t              out_kind_reg;
    logic [BYTE_W-1:0]  out_byte_reg;
    logic [COUNT_W-1:0] out_col_reg;
    logic               out_ovf_reg;
    logic               out_last_reg;

    logic               pend_wr;
    logic               unquoted;
    logic               c_space;
    logic               c_delim;
    logic [COUNT_W-1:0] fields_inc;
    logic               load;

    // whitespace and delimiter classes
    always_comb
    begin
        c_space = (text.char_byte == SPACE_CH) ||
                  ((text.char_byte >= TAB_CH) && (text.char_byte <= CR_CH));
        c_delim = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            if ((delim_reg[i] != '0) && (delim_reg[i] == text.char_byte))
            begin
                c_delim = 1'b1;
            end
        end
    end

    assign fields_inc = (fields_reg == COUNT_MAX) ? fields_reg : fields_reg + COUNT_W'(1);

    always_comb
    begin
        inside_quotes_next  = inside_quotes_reg;
        quote_seen_next     = quote_seen_reg;
        field_quoted_next   = field_quoted_reg;
        line_blank_next     = line_blank_reg;
        field_nonempty_next = field_nonempty_reg;
        line_finished_next  = line_finished_reg;
        pending_count_next  = pending_count_reg;
        fields_next         = fields_reg;
        overflow_next       = overflow_reg;
        plan_byte_next      = plan_byte_reg;
        plan_fend_next      = plan_fend_reg;
        plan_lend_next      = plan_lend_reg;
        flush_n_next        = flush_n_reg;
        flush_idx_next      = flush_idx_reg;
        char_next           = char_reg;
        col_next            = col_reg;
        ovf_hold_next       = ovf_hold_reg;
        pend_wr             = 1'b0;
        unquoted            = 1'b0;

        if (cmd.accept)
        begin
            char_next      = text.char_byte;
            plan_byte_next = 1'b0;
            plan_fend_next = 1'b0;
            plan_lend_next = 1'b0;
            flush_n_next   = '0;
            flush_idx_next = '0;
            if (text.action)
            begin
                plan_fend_next      = !line_blank_reg;
                plan_lend_next      = 1'b1;
                col_next            = line_blank_reg ? fields_reg : fields_inc;
                ovf_hold_next       = overflow_reg;
                inside_quotes_next  = 1'b0;
                quote_seen_next     = 1'b0;
                field_quoted_next   = 1'b0;
                line_blank_next     = 1'b1;
                field_nonempty_next = 1'b0;
                line_finished_next  = 1'b0;
                pending_count_next  = '0;
                fields_next         = '0;
                overflow_next       = 1'b0;
            end
            else
            begin
                if (!line_finished_reg)
                begin
                    if (inside_quotes_reg)
                    begin
                        if (quote_seen_reg)
                        begin
                            quote_seen_next = 1'b0;
                            if (text.char_byte == QUOTE_CH)
                            begin
                                field_nonempty_next = 1'b1;
                                plan_byte_next      = 1'b1;
                            end
                            else
                            begin
                                inside_quotes_next = 1'b0;
                                unquoted           = 1'b1;
                            end
                        end
                        else if (text.char_byte == QUOTE_CH)
                        begin
                            quote_seen_next = 1'b1;
                        end
                        else
                        begin
                            field_nonempty_next = 1'b1;
                            plan_byte_next      = 1'b1;
                        end
                    end
                    else
                    begin
                        unquoted = 1'b1;
                    end
                end

                if (unquoted)
                begin
                    priority if ((text.char_byte == LF_CH) || (text.char_byte == CR_CH))
                    begin
                        line_finished_next = 1'b1;
                    end
                    else if (text.char_byte == QUOTE_CH)
                    begin
                        flush_n_next       = pending_count_reg;
                        pending_count_next = '0;
                        inside_quotes_next = 1'b1;
                        field_quoted_next  = 1'b1;
                        line_blank_next    = 1'b0;
                    end
                    else if (!field_nonempty_reg && c_space)
                    begin
                        // leading whitespace skipped
                    end
                    else if (c_delim)
                    begin
                        pending_count_next  = '0;
                        plan_fend_next      = 1'b1;
                        fields_next         = fields_inc;
                        field_quoted_next   = 1'b0;
                        field_nonempty_next = 1'b0;
                    end
                    else
                    begin
                        line_blank_next     = 1'b0;
                        field_nonempty_next = 1'b1;
                        if (c_space && !field_quoted_reg)
                        begin
                            if (pending_count_reg < PCNT_W'(PENDING_DEPTH))
                            begin
                                pend_wr            = 1'b1;
                                pending_count_next = pending_count_reg + PCNT_W'(1);
                            end
                            else
                            begin
                                overflow_next = 1'b1;
                            end
                        end
                        else
                        begin
                            flush_n_next       = pending_count_reg;
                            pending_count_next = '0;
                            plan_byte_next     = 1'b1;
                        end
                    end
                end
                ovf_hold_next = overflow_next;
            end
        end
        else
        begin
            unique case (cmd.sel)
                SEL_PEND: flush_idx_next = flush_idx_reg + PCNT_W'(1);
                SEL_BYTE: plan_byte_next = 1'b0;
                SEL_FEND: plan_fend_next = 1'b0;
                SEL_LEND: plan_lend_next = 1'b0;
                default:  ;
            endcase
        end
    end

    assign load           = (cmd.sel != SEL_NONE);
    assign out_valid_next = load ? 1'b1 : (result.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg[0]       <= DELIM_0_RESET;
            delim_reg[1]       <= '0;
            delim_reg[2]       <= '0;
            delim_reg[3]       <= '0;
            inside_quotes_reg  <= 1'b0;
            quote_seen_reg     <= 1'b0;
            field_quoted_reg   <= 1'b0;
            line_blank_reg     <= 1'b1;
            field_nonempty_reg <= 1'b0;
            line_finished_reg  <= 1'b0;
            pending_count_reg  <= '0;
            fields_reg         <= '0;
            overflow_reg       <= 1'b0;
            plan_byte_reg      <= 1'b0;
            plan_fend_reg      <= 1'b0;
            plan_lend_reg      <= 1'b0;
            flush_n_reg        <= '0;
            flush_idx_reg      <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (setup.valid)
            begin
                unique case (setup.index)
                    REG_DELIMITER_0: delim_reg[0] <= setup.data;
                    REG_DELIMITER_1: delim_reg[1] <= setup.data;
                    REG_DELIMITER_2: delim_reg[2] <= setup.data;
                    REG_DELIMITER_3: delim_reg[3] <= setup.data;
                    default:         ;
                endcase
            end
            inside_quotes_reg  <= inside_quotes_next;
            quote_seen_reg     <= quote_seen_next;
            field_quoted_reg   <= field_quoted_next;
            line_blank_reg     <= line_blank_next;
            field_nonempty_reg <= field_nonempty_next;
            line_finished_reg  <= line_finished_next;
            pending_count_reg  <= pending_count_next;
            fields_reg         <= fields_next;
            overflow_reg       <= overflow_next;
            plan_byte_reg      <= plan_byte_next;
            plan_fend_reg      <= plan_fend_next;
            plan_lend_reg      <= plan_lend_next;
            flush_n_reg        <= flush_n_next;
            flush_idx_reg      <= flush_idx_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_wr)
        begin
            pending_space_reg[pending_count_reg[PIDX_W-1:0]] <= text.char_byte;
        end
        char_reg     <= char_next;
        col_reg      <= col_next;
        ovf_hold_reg <= ovf_hold_next;
        if (load)
        begin
            out_ovf_reg  <= ovf_hold_reg;
            out_last_reg <= cmd.last;
            unique case (cmd.sel)
                SEL_PEND:
                begin
                    out_kind_reg <= KIND_BYTE;
                    out_byte_reg <= pending_space_reg[flush_idx_reg[PIDX_W-1:0]];
                    out_col_reg  <= '0;
                end
                SEL_BYTE:
                begin
                    out_kind_reg <= KIND_BYTE;
                    out_byte_reg <= char_reg;
                    out_col_reg  <= '0;
                end
                SEL_FEND:
                begin
                    out_kind_reg <= KIND_FIELD_END;
                    out_byte_reg <= '0;
                    out_col_reg  <= '0;
                end
                default:
                begin
                    out_kind_reg <= KIND_LINE_END;
                    out_byte_reg <= '0;
                    out_col_reg  <= col_reg;
                end
            endcase
        end
    end

    assign sts.out_free    = !out_valid_reg || result.ready;
    assign sts.flush_left  = (flush_idx_reg != flush_n_reg);
    assign sts.flush_final = ((flush_idx_reg + PCNT_W'(1)) == flush_n_reg);
    assign sts.plan_byte   = plan_byte_reg;
    assign sts.plan_fend   = plan_fend_reg;
    assign sts.plan_lend   = plan_lend_reg;

    assign setup.ready          = 1'b1;
    assign result.valid         = out_valid_reg;
    assign result.kind          = out_kind_reg;
    assign result.field_byte    = out_byte_reg;
    assign result.column_count  = out_col_reg;
    assign result.trim_overflow = out_ovf_reg;
    assign result.last          = out_last_reg;

endmodule
